// File: hw/rtl/swk_pkg.sv
`timescale 1ns / 1ps
package swk_pkg;

    localparam int CORDIC_STAGES_DEF = 16;
    localparam int FRACTION_BITS_DEF = 15;

    // angle accumulator width inside the CORDIC (32 bit binary angle plus headroom)
    localparam int ANGLE_W = 34;

    localparam logic [31:0] INV_GAIN     = 32'd2608131496;  // 1/K * 2^32
    localparam logic [31:0] INV_SQRT2    = 32'd3037000500;  // 1/sqrt2 * 2^32
    localparam logic [31:0] HALF_TURN    = 32'h8000_0000;
    localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;

    // floor(n / 9) = (n * RECIP9) >> RECIP9_SHIFT, exact for n < 2^19
    localparam logic [19:0] RECIP9       = 20'd932068;
    localparam int          RECIP9_SHIFT = 23;

    localparam logic [15:0] SCALE_ONE = 16'h8000;

    typedef struct packed {
        logic signed [15:0] x_command;
        logic signed [15:0] y_command;
        logic signed [15:0] rotation_command;
        logic        [15:0] speed_scale;
        logic               field_oriented;
        logic        [15:0] robot_heading;
        logic        [15:0] front_left_angle;
        logic        [15:0] front_right_angle;
        logic        [15:0] back_left_angle;
        logic        [15:0] back_right_angle;
    } t_cmd;

    typedef struct packed {
        logic [15:0] front_left_speed;
        logic [15:0] front_right_speed;
        logic [15:0] back_left_speed;
        logic [15:0] back_right_speed;
        logic [15:0] front_left_steer;
        logic [15:0] front_right_steer;
        logic [15:0] back_left_steer;
        logic [15:0] back_right_steer;
    } t_wheels;

    // arctan(2^-i) as 32 bit binary angle
    function automatic logic [31:0] arc_angle(input logic [4:0] idx);
        logic [31:0] a;
        case (idx)
            5'd0:    a = 32'h20000000;
            5'd1:    a = 32'h12E4051E;
            5'd2:    a = 32'h09FB385B;
            5'd3:    a = 32'h051111D4;
            5'd4:    a = 32'h028B0D43;
            5'd5:    a = 32'h0145D7E1;
            5'd6:    a = 32'h00A2F61E;
            5'd7:    a = 32'h00517C55;
            5'd8:    a = 32'h0028BE53;
            5'd9:    a = 32'h00145F2F;
            5'd10:   a = 32'h000A2F98;
            5'd11:   a = 32'h000517CC;
            5'd12:   a = 32'h00028BE6;
            5'd13:   a = 32'h000145F3;
            5'd14:   a = 32'h0000A2FA;
            5'd15:   a = 32'h0000517D;
            5'd16:   a = 32'h000028BE;
            5'd17:   a = 32'h0000145F;
            5'd18:   a = 32'h00000A30;
            5'd19:   a = 32'h00000518;
            5'd20:   a = 32'h0000028C;
            5'd21:   a = 32'h00000146;
            5'd22:   a = 32'h000000A3;
            5'd23:   a = 32'h00000051;
            default: a = 32'h00000000;
        endcase
        return a;
    endfunction

endpackage

// File: hw/rtl/swk_cordic.sv
`timescale 1ns / 1ps
module swk_cordic #(
    parameter int   STAGES = 16,
    parameter int   WIDTH  = 20,
    parameter logic ROTATE = 1'b1
) (
    input  logic                    i_clk,
    input  logic                    i_en,
    input  logic signed [WIDTH-1:0] i_x,
    input  logic signed [WIDTH-1:0] i_y,
    input  logic        [31:0]      i_z,
    output logic signed [WIDTH-1:0] o_x,
    output logic signed [WIDTH-1:0] o_y,
    output logic        [31:0]      o_z
);
    import swk_pkg::*;

    localparam logic signed [ANGLE_W-1:0] Z_HALF    = $signed(ANGLE_W'(HALF_TURN));
    localparam logic signed [ANGLE_W-1:0] Z_QUARTER = $signed(ANGLE_W'(QUARTER_TURN));

    // index 0 is the quadrant fold, 1..STAGES the micro-rotations
    logic signed [WIDTH-1:0]   r_x [STAGES+1];
    logic signed [WIDTH-1:0]   r_y [STAGES+1];
    logic signed [ANGLE_W-1:0] r_z [STAGES+1];

    logic signed [WIDTH-1:0]   n_x [STAGES+1];
    logic signed [WIDTH-1:0]   n_y [STAGES+1];
    logic signed [ANGLE_W-1:0] n_z [STAGES+1];

    logic signed [ANGLE_W-1:0] z_in;

    always_comb begin
        z_in = ANGLE_W'($signed(i_z));
        n_x[0] = i_x;
        n_y[0] = i_y;
        n_z[0] = z_in;
        if (ROTATE) begin
            if (z_in > Z_QUARTER) begin
                n_x[0] = -i_x;
                n_y[0] = -i_y;
                n_z[0] = z_in - Z_HALF;
            end else if (z_in < -Z_QUARTER) begin
                n_x[0] = -i_x;
                n_y[0] = -i_y;
                n_z[0] = z_in + Z_HALF;
            end
        end else begin
            n_z[0] = '0;
            if (i_x < 0) begin
                n_x[0] = -i_x;
                n_y[0] = -i_y;
                n_z[0] = Z_HALF;
            end
        end

        for (int i = 1; i <= STAGES; i++) begin
            logic                      sel;
            logic signed [ANGLE_W-1:0] arc;
            arc = $signed(ANGLE_W'(arc_angle(5'(i - 1))));
            sel = ROTATE ? (r_z[i-1] < 0) : (r_y[i-1] >= 0);
            if (sel) begin
                n_x[i] = r_x[i-1] + (r_y[i-1] >>> (i - 1));
                n_y[i] = r_y[i-1] - (r_x[i-1] >>> (i - 1));
                n_z[i] = r_z[i-1] + arc;
            end else begin
                n_x[i] = r_x[i-1] - (r_y[i-1] >>> (i - 1));
                n_y[i] = r_y[i-1] + (r_x[i-1] >>> (i - 1));
                n_z[i] = r_z[i-1] - arc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i <= STAGES; i++) begin
                r_x[i] <= n_x[i];
                r_y[i] <= n_y[i];
                r_z[i] <= n_z[i];
            end
        end
    end

    assign o_x = r_x[STAGES];
    assign o_y = r_y[STAGES];
    assign o_z = r_z[STAGES][31:0];

endmodule

// File: hw/rtl/swk_isqrt.sv
`timescale 1ns / 1ps
module swk_isqrt #(
    parameter int ROOT_BITS = 17
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic [2*ROOT_BITS-1:0]   i_value,
    output logic [ROOT_BITS-1:0]     o_root
);
    import swk_pkg::*;

    localparam int RW = ROOT_BITS + 2;

    // one root bit per stage, most significant first
    logic [RW-1:0]          r_rem  [ROOT_BITS];
    logic [ROOT_BITS-1:0]   r_root [ROOT_BITS];
    logic [2*ROOT_BITS-1:0] r_val  [ROOT_BITS];

    logic [RW-1:0]          rem_in  [ROOT_BITS];
    logic [ROOT_BITS-1:0]   root_in [ROOT_BITS];
    logic [2*ROOT_BITS-1:0] val_in  [ROOT_BITS];
    logic [RW-1:0]          n_rem   [ROOT_BITS];
    logic [ROOT_BITS-1:0]   n_root  [ROOT_BITS];

    always_comb begin
        rem_in[0]  = '0;
        root_in[0] = '0;
        val_in[0]  = i_value;
        for (int i = 1; i < ROOT_BITS; i++) begin
            rem_in[i]  = r_rem[i-1];
            root_in[i] = r_root[i-1];
            val_in[i]  = r_val[i-1];
        end
        for (int i = 0; i < ROOT_BITS; i++) begin
            logic [RW-1:0] sh;
            logic [RW-1:0] trial;
            logic          ge;
            sh    = {rem_in[i][ROOT_BITS-1:0], val_in[i][2*(ROOT_BITS-1-i) +: 2]};
            trial = {root_in[i], 2'b01};
            ge    = (sh >= trial);
            n_rem[i]  = ge ? (sh - trial) : sh;
            n_root[i] = {root_in[i][ROOT_BITS-2:0], ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < ROOT_BITS; i++) begin
                r_rem[i]  <= n_rem[i];
                r_root[i] <= n_root[i];
                r_val[i]  <= val_in[i];
            end
        end
    end

    assign o_root = r_root[ROOT_BITS-1];

endmodule

// File: hw/rtl/swerve_wheel_kinematics.sv
`timescale 1ns / 1ps
// Swerve drive inverse kinematics, four modules.
//
// Input channel: i_valid / o_stall with one drive command (t_cmd) per transfer.
// Output channel: o_valid / i_stall with the four wheel speeds and steering
// targets (t_wheels) per transfer. A transfer happens on a rising edge with
// valid high and stall low.
//
// Throughput: one command per cycle while the output is not held by i_stall.
// The pipeline depth is set by the heading CORDIC, the bit-per-stage square
// root and the bit-per-stage normalizing divider, all fully pipelined.
//
// The whole pipeline advances as one: when a result is held by i_stall every
// stage holds and o_stall rises, so nothing is lost or repeated. Bubbles flow
// through as invalid slots.
//
// Reset (synchronous, active low) clears the stage valid bits only.
module swerve_wheel_kinematics #(
    parameter int CORDIC_STAGES = swk_pkg::CORDIC_STAGES_DEF,
    parameter int FRACTION_BITS = swk_pkg::FRACTION_BITS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  swk_pkg::t_cmd   i_cmd,
    output logic            o_valid,
    input  logic            i_stall,
    output swk_pkg::t_wheels o_wheels
);
    import swk_pkg::*;

    localparam int F    = FRACTION_BITS;
    localparam int N    = CORDIC_STAGES;
    localparam int CW   = F + 5;          // signed vector components
    localparam int AW   = F + 2;          // component magnitude
    localparam int SW   = F + 2;          // wheel speed before normalizing
    localparam int VW   = 2 * SW;         // sum of squares
    localparam int QW   = F + 1;          // normalized speed
    localparam int DS   = F + 1;          // divider steps
    localparam int UP   = (F >= 15) ? F - 15 : 0;
    localparam int DN   = (F < 15) ? 15 - F : 0;
    localparam int LR   = N + 2;          // heading CORDIC + gain stage
    localparam int D2   = SW + F + 4;     // stage A to last divider step
    localparam int DSL  = 2 * F + 5 - N;  // steer alignment
    localparam int LAT  = N + 2 * F + 12;

    localparam logic signed [32:0] GAIN_S  = {1'b0, INV_GAIN};
    localparam logic signed [32:0] SQRT2_S = {1'b0, INV_SQRT2};
    localparam logic [SW-1:0]      ONE_SW  = SW'(1) << F;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] rs;
        logic                 field;
        logic                 zero;
        logic [15:0]          scale;
        logic [3:0][15:0]     hold;
    } t_side1;

    typedef struct packed {
        logic             zero;
        logic [15:0]      scale;
        logic [3:0][15:0] hold;
    } t_side2;

    logic w_en;
    assign w_en    = !(o_valid && i_stall);
    assign o_stall = !w_en;

    // valid bit per pipeline slot
    logic [LAT-1:0] r_vld;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[LAT-2:0], i_valid};
        end
    end
    assign o_valid = r_vld[LAT-1];

    // ---- input register
    t_cmd r_cmd;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_cmd <= i_cmd;
        end
    end

    // ---- P1: convert to internal format, r/sqrt2, held steer, scale clamp
    logic signed [CW-1:0] n_xi, n_yi, n_ri;
    logic signed [CW+32:0] n_rs_p;
    logic [15:0]  ang [4];
    logic [38:0]  n_hold_p [4];
    t_side1       n_p1;
    t_side1       r_p1;
    logic [31:0]  r_p1_ang;

    assign n_xi   = (CW'(r_cmd.x_command) <<< UP) >>> DN;
    assign n_yi   = (CW'(r_cmd.y_command) <<< UP) >>> DN;
    assign n_ri   = (CW'(r_cmd.rotation_command) <<< UP) >>> DN;
    assign n_rs_p = n_ri * SQRT2_S;

    assign ang[0] = r_cmd.front_left_angle;
    assign ang[1] = r_cmd.front_right_angle;
    assign ang[2] = r_cmd.back_left_angle;
    assign ang[3] = r_cmd.back_right_angle;

    always_comb begin
        n_p1.x     = n_xi;
        n_p1.y     = n_yi;
        n_p1.rs    = n_rs_p[CW+31:32];
        n_p1.field = r_cmd.field_oriented;
        n_p1.zero  = (r_cmd.x_command == 16'sd0) && (r_cmd.y_command == 16'sd0)
                     && (r_cmd.rotation_command == 16'sd0);
        n_p1.scale = (r_cmd.speed_scale > SCALE_ONE) ? SCALE_ONE : r_cmd.speed_scale;
        for (int k = 0; k < 4; k++) begin
            // angle * 8 / 9 via reciprocal
            n_hold_p[k] = 39'({ang[k], 3'b000}) * 39'(RECIP9);
            n_p1.hold[k] = 16'(n_hold_p[k] >> RECIP9_SHIFT);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p1     <= n_p1;
            r_p1_ang <= 32'd0 - {r_cmd.robot_heading, 16'h0000};
        end
    end

    // ---- heading rotation
    logic signed [CW-1:0] c_rx, c_ry;
    logic [31:0]          c_rz;

    swk_cordic #(
        .STAGES (N),
        .WIDTH  (CW),
        .ROTATE (1'b1)
    ) u_rot (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_x   (r_p1.x),
        .i_y   (r_p1.y),
        .i_z   (r_p1_ang),
        .o_x   (c_rx),
        .o_y   (c_ry),
        .o_z   (c_rz)
    );

    // gain compensation
    logic signed [CW+32:0] n_gx, n_gy;
    logic signed [CW-1:0]  r_gx, r_gy;
    assign n_gx = c_rx * GAIN_S;
    assign n_gy = c_ry * GAIN_S;

    // side data rides along the rotation
    t_side1 r_dl1 [LR];
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_gx <= n_gx[CW+31:32];
            r_gy <= n_gy[CW+31:32];
            r_dl1[0] <= r_p1;
            for (int i = 1; i < LR; i++) begin
                r_dl1[i] <= r_dl1[i-1];
            end
        end
    end

    // ---- stage A: wheel component pairs
    logic signed [CW-1:0] n_strafe, n_fwd, n_front, n_back, n_left, n_right;
    logic signed [CW-1:0] n_ca [4];
    logic signed [CW-1:0] n_cb [4];
    logic signed [CW-1:0] r_a_ca [4];
    logic signed [CW-1:0] r_a_cb [4];
    logic [3:0]           n_wz, r_a_wz;
    t_side2               r_a_side;

    always_comb begin
        n_strafe = r_dl1[LR-1].field ? r_gx : r_dl1[LR-1].x;
        n_fwd    = r_dl1[LR-1].field ? r_gy : r_dl1[LR-1].y;
        n_front  = n_strafe + r_dl1[LR-1].rs;
        n_back   = n_strafe - r_dl1[LR-1].rs;
        n_left   = n_fwd + r_dl1[LR-1].rs;
        n_right  = n_fwd - r_dl1[LR-1].rs;
        n_ca[0] = n_front; n_cb[0] = n_left;
        n_ca[1] = n_front; n_cb[1] = n_right;
        n_ca[2] = n_back;  n_cb[2] = n_left;
        n_ca[3] = n_back;  n_cb[3] = n_right;
        for (int k = 0; k < 4; k++) begin
            n_wz[k] = (n_ca[k] == '0) && (n_cb[k] == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < 4; k++) begin
                r_a_ca[k] <= n_ca[k];
                r_a_cb[k] <= n_cb[k];
            end
            r_a_wz         <= n_wz;
            r_a_side.zero  <= r_dl1[LR-1].zero;
            r_a_side.scale <= r_dl1[LR-1].scale;
            r_a_side.hold  <= r_dl1[LR-1].hold;
        end
    end

    // ---- speed path: squares, sum, root
    logic [AW-1:0] n_abs_a [4];
    logic [AW-1:0] n_abs_b [4];
    logic [VW-1:0] r_sq_a  [4];
    logic [VW-1:0] r_sq_b  [4];
    logic [VW-1:0] r_sum   [4];
    logic [SW-1:0] w_root  [4];

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            n_abs_a[k] = AW'(r_a_ca[k][CW-1] ? -r_a_ca[k] : r_a_ca[k]);
            n_abs_b[k] = AW'(r_a_cb[k][CW-1] ? -r_a_cb[k] : r_a_cb[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < 4; k++) begin
                r_sq_a[k] <= VW'(n_abs_a[k]) * VW'(n_abs_a[k]);
                r_sq_b[k] <= VW'(n_abs_b[k]) * VW'(n_abs_b[k]);
                r_sum[k]  <= r_sq_a[k] + r_sq_b[k];
            end
        end
    end

    for (genvar k = 0; k < 4; k++) begin : g_root
        swk_isqrt #(
            .ROOT_BITS (SW)
        ) u_root (
            .i_clk   (i_clk),
            .i_en    (w_en),
            .i_value (r_sum[k]),
            .o_root  (w_root[k])
        );
    end

    // ---- largest speed picks the divisor; 1.0 when no normalizing needed
    logic [SW-1:0] n_m01, n_m23, n_max;
    logic [SW-1:0] r_mx_m [4];
    logic [SW-1:0] r_mx_d;

    assign n_m01 = (w_root[1] > w_root[0]) ? w_root[1] : w_root[0];
    assign n_m23 = (w_root[3] > w_root[2]) ? w_root[3] : w_root[2];
    assign n_max = (n_m23 > n_m01) ? n_m23 : n_m01;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < 4; k++) begin
                r_mx_m[k] <= w_root[k];
            end
            r_mx_d <= (n_max > ONE_SW) ? n_max : ONE_SW;
        end
    end

    // ---- restoring divider, one quotient bit per stage: m * 2^F / divisor
    logic [SW:0]   r_dv_rem [DS][4];
    logic [QW-1:0] r_dv_q   [DS][4];
    logic [SW-1:0] r_dv_d   [DS];

    logic [SW:0]   dv_rin  [DS][4];
    logic [QW-1:0] dv_qin  [DS][4];
    logic [SW-1:0] dv_din  [DS];
    logic [SW:0]   n_dv_rem [DS][4];
    logic [QW-1:0] n_dv_q   [DS][4];

    always_comb begin
        dv_din[0] = r_mx_d;
        for (int k = 0; k < 4; k++) begin
            dv_rin[0][k] = {1'b0, r_mx_m[k]};
            dv_qin[0][k] = '0;
        end
        for (int s = 1; s < DS; s++) begin
            dv_din[s] = r_dv_d[s-1];
            for (int k = 0; k < 4; k++) begin
                dv_rin[s][k] = {r_dv_rem[s-1][k][SW-1:0], 1'b0};
                dv_qin[s][k] = r_dv_q[s-1][k];
            end
        end
        for (int s = 0; s < DS; s++) begin
            for (int k = 0; k < 4; k++) begin
                logic ge;
                ge = (dv_rin[s][k] >= {1'b0, dv_din[s]});
                n_dv_rem[s][k] = ge ? (dv_rin[s][k] - {1'b0, dv_din[s]}) : dv_rin[s][k];
                n_dv_q[s][k]   = {dv_qin[s][k][QW-2:0], ge};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int s = 0; s < DS; s++) begin
                r_dv_d[s] <= dv_din[s];
                for (int k = 0; k < 4; k++) begin
                    r_dv_rem[s][k] <= n_dv_rem[s][k];
                    r_dv_q[s][k]   <= n_dv_q[s][k];
                end
            end
        end
    end

    // ---- steering path: vectoring CORDIC per wheel
    logic signed [CW-1:0] v_x [4];
    logic signed [CW-1:0] v_y [4];
    logic [31:0]          v_z [4];

    for (genvar k = 0; k < 4; k++) begin : g_vec
        swk_cordic #(
            .STAGES (N),
            .WIDTH  (CW),
            .ROTATE (1'b0)
        ) u_vec (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_x   (r_a_cb[k]),
            .i_y   (r_a_ca[k]),
            .i_z   (32'd0),
            .o_x   (v_x[k]),
            .o_y   (v_y[k]),
            .o_z   (v_z[k])
        );
    end

    // zero-vector flags ride along the vectoring stages
    logic [3:0]       r_wz_dl [N+1];
    logic [3:0][15:0] n_steer;
    logic [3:0][15:0] r_dst [DSL];

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            logic [31:0] neg;
            logic [34:0] prod;
            neg  = 32'd0 - v_z[k];
            prod = 35'(neg) * 35'd5;
            // full turn maps to 5 units in Q3.13
            n_steer[k] = r_wz_dl[N][k] ? 16'd0 : prod[34:19];
        end
    end

    // v_x / v_y carry the scaled magnitude, not needed here
    logic [3:0] w_vec_unused;
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            w_vec_unused[k] = ^{v_x[k], v_y[k]};
        end
    end

    t_side2 r_dl2 [D2];
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_wz_dl[0] <= r_a_wz;
            for (int i = 1; i <= N; i++) begin
                r_wz_dl[i] <= r_wz_dl[i-1];
            end
            r_dst[0] <= n_steer;
            for (int i = 1; i < DSL; i++) begin
                r_dst[i] <= r_dst[i-1];
            end
            r_dl2[0] <= r_a_side;
            for (int i = 1; i < D2; i++) begin
                r_dl2[i] <= r_dl2[i-1];
            end
        end
    end

    // ---- output register: scale, or stop and hold on an all-zero command
    logic [QW+15:0]   n_sp_p [4];
    logic [3:0][15:0] n_speed;
    logic [3:0][15:0] n_st;
    t_wheels          n_out;
    t_wheels          r_out;

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            n_sp_p[k]  = (QW+16)'(r_dv_q[DS-1][k]) * (QW+16)'(r_dl2[D2-1].scale);
            n_speed[k] = r_dl2[D2-1].zero ? 16'd0 : n_sp_p[k][F+15:F];
            n_st[k]    = r_dl2[D2-1].zero ? r_dl2[D2-1].hold[k] : r_dst[DSL-1][k];
        end
        n_out.front_left_speed  = n_speed[0];
        n_out.front_right_speed = n_speed[1];
        n_out.back_left_speed   = n_speed[2];
        n_out.back_right_speed  = n_speed[3];
        n_out.front_left_steer  = n_st[0];
        n_out.front_right_steer = n_st[1];
        n_out.back_left_steer   = n_st[2];
        n_out.back_right_steer  = n_st[3];
        // keep the unused CORDIC outputs folded in without effect
        if (w_vec_unused == 4'b0000 && c_rz == 32'd0 && 1'b0) begin
            n_out.front_left_steer = n_st[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out <= n_out;
        end
    end

    assign o_wheels = r_out;

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
module testbench;
    import swk_pkg::*;

    // Block parameters; the predictor follows the same values.
    localparam int STAGES = 16;
    localparam int FRAC = 15;
    localparam int LATENCY = STAGES + 2 * FRAC + 12;
    localparam int N_RANDOM = 1830;

    logic    clk = 1'b0;
    logic    rst_n = 1'b0;
    logic    cmd_valid = 1'b0;
    logic    cmd_stall;
    t_cmd    cmd = '0;
    logic    wheels_valid;
    logic    wheels_stall = 1'b0;
    t_wheels wheels;

    // Idle/stall pressure: percent of cycles. Zero during the quiet stretch.
    int      send_idle_pct = 21;
    int      recv_stall_pct = 21;

    t_wheels expected_wheels[$];
    int      n_errors = 0;
    int      n_sent = 0;
    int      n_checked = 0;
    int      n_zero_cmd = 0;
    int      n_field = 0;

    swerve_wheel_kinematics #(
        .CORDIC_STAGES(STAGES),
        .FRACTION_BITS(FRAC)
    ) i_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_valid (cmd_valid),
        .o_stall (cmd_stall),
        .i_cmd   (cmd),
        .o_valid (wheels_valid),
        .i_stall (wheels_stall),
        .o_wheels(wheels)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ---------------------------------------------------------------------
    // Predictor: plain fixed-point arithmetic at 64 bits.
    // ---------------------------------------------------------------------

    // Floor division by 2^s; >>> on a signed longint is already a floor.
    function automatic longint fshr(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint arctan_step(int i);
        case (i)
            0:  return 64'h20000000;
            1:  return 64'h12E4051E;
            2:  return 64'h09FB385B;
            3:  return 64'h051111D4;
            4:  return 64'h028B0D43;
            5:  return 64'h0145D7E1;
            6:  return 64'h00A2F61E;
            7:  return 64'h00517C55;
            8:  return 64'h0028BE53;
            9:  return 64'h00145F2F;
            10: return 64'h000A2F98;
            11: return 64'h000517CC;
            12: return 64'h00028BE6;
            13: return 64'h000145F3;
            14: return 64'h0000A2FA;
            15: return 64'h0000517D;
            16: return 64'h000028BE;
            17: return 64'h0000145F;
            18: return 64'h00000A30;
            19: return 64'h00000518;
            20: return 64'h0000028C;
            21: return 64'h00000146;
            22: return 64'h000000A3;
            23: return 64'h00000051;
            default: return 0;
        endcase
    endfunction

    function automatic longint q15_to_int(longint v);
        if (FRAC >= 15) return v * (64'sd1 << (FRAC - 15));
        return fshr(v, 15 - FRAC);
    endfunction

    // Rotate (x, y) by a 32 bit binary angle, gain-compensated.
    function automatic void rotate_by_heading(inout longint x, inout longint y,
                                              input bit [31:0] ang);
        longint z, nx;
        int     n;
        n = (STAGES > 24) ? 24 : STAGES;
        z = longint'(ang[30:0]) - (ang[31] ? 64'sh8000_0000 : 0);
        if (z > 64'sh4000_0000) begin
            x = -x; y = -y; z -= 64'sh8000_0000;
        end else if (z < -64'sh4000_0000) begin
            x = -x; y = -y; z += 64'sh8000_0000;
        end
        for (int i = 0; i < n; i++) begin
            if (z >= 0) begin
                nx = x - fshr(y, i);
                y  = y + fshr(x, i);
                z -= arctan_step(i);
            end else begin
                nx = x + fshr(y, i);
                y  = y - fshr(x, i);
                z += arctan_step(i);
            end
            x = nx;
        end
        x = fshr(x * 64'sd2608131496, 32);
        y = fshr(y * 64'sd2608131496, 32);
    endfunction

    function automatic bit [15:0] steer_target(longint a, longint b);
        longint   x, y, nx, z;
        bit [31:0] neg;
        bit [63:0] prod;
        int       n;
        n = (STAGES > 24) ? 24 : STAGES;
        if (a == 0 && b == 0) return 16'd0;
        x = b; y = a; z = 0;
        if (x < 0) begin
            x = -x; y = -y; z = 64'sh8000_0000;
        end
        for (int i = 0; i < n; i++) begin
            if (y >= 0) begin
                nx = x + fshr(y, i);
                y  = y - fshr(x, i);
                z += arctan_step(i);
            end else begin
                nx = x - fshr(y, i);
                y  = y + fshr(x, i);
                z -= arctan_step(i);
            end
            x = nx;
        end
        neg = 32'd0 - z[31:0];
        prod = (64'(neg) * 64'd5) >> 19;
        return prod[15:0];
    endfunction

    function automatic longint unsigned isqrt(longint unsigned v);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic t_wheels wheel_targets(t_cmd c);
        t_wheels         w;
        longint          x, y, r, rs, strafe, fwd;
        longint          ca[4], cb[4];
        longint unsigned m[4], maxm, one, sc, s, ua, ub;
        bit [15:0]       spd[4], str[4];
        bit [15:0]       ang[4];
        bit [63:0]       tmp;
        x = longint'(c.x_command);
        y = longint'(c.y_command);
        r = longint'(c.rotation_command);
        sc = (c.speed_scale > 16'h8000) ? 64'd32768 : 64'(c.speed_scale);
        one = 64'd1 << FRAC;
        ang = '{c.front_left_angle, c.front_right_angle, c.back_left_angle,
                c.back_right_angle};
        if (x == 0 && y == 0 && r == 0) begin
            // Stopped: hold each module at its present angle * 8 / 9.
            for (int k = 0; k < 4; k++) begin
                spd[k] = '0;
                tmp = (64'(ang[k]) * 8) / 9;
                str[k] = tmp[15:0];
            end
        end else begin
            strafe = q15_to_int(x);
            fwd = q15_to_int(y);
            if (c.field_oriented)
                rotate_by_heading(strafe, fwd, 32'd0 - {c.robot_heading, 16'd0});
            rs = fshr(q15_to_int(r) * 64'sd3037000500, 32);
            ca = '{strafe + rs, strafe + rs, strafe - rs, strafe - rs};
            cb = '{fwd + rs, fwd - rs, fwd + rs, fwd - rs};
            maxm = 0;
            for (int k = 0; k < 4; k++) begin
                ua = (ca[k] < 0) ? -ca[k] : ca[k];
                ub = (cb[k] < 0) ? -cb[k] : cb[k];
                m[k] = isqrt(ua * ua + ub * ub);
                if (m[k] > maxm) maxm = m[k];
            end
            for (int k = 0; k < 4; k++) begin
                s = m[k];
                if (maxm > one) s = (s * one) / maxm;
                tmp = (s * sc) >> FRAC;
                spd[k] = tmp[15:0];
                str[k] = steer_target(ca[k], cb[k]);
            end
        end
        w.front_left_speed  = spd[0];
        w.front_right_speed = spd[1];
        w.back_left_speed   = spd[2];
        w.back_right_speed  = spd[3];
        w.front_left_steer  = str[0];
        w.front_right_steer = str[1];
        w.back_left_steer   = str[2];
        w.back_right_steer  = str[3];
        return w;
    endfunction

    // ---------------------------------------------------------------------
    // Sender: one command transfer. Valid is raised at an edge and held
    // until the edge at which stall is low. Idle gaps are inserted first.
    // ---------------------------------------------------------------------
    task automatic send_command(t_cmd c);
        while ($urandom_range(99) < send_idle_pct) begin
            cmd_valid <= 1'b0;
            @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd <= c;
        @(posedge clk);
        while (cmd_stall) @(posedge clk);
        // Transfer done at this edge; the expectation is queued in the
        // same step, before the result can possibly appear.
        expected_wheels.push_back(wheel_targets(c));
        n_sent++;
        if (c.x_command == 0 && c.y_command == 0 && c.rotation_command == 0)
            n_zero_cmd++;
        if (c.field_oriented) n_field++;
    endtask

    // Receiver stall, drawn per cycle.
    always @(posedge clk) begin
        wheels_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // Result checker: sampled at the edge, before NBA updates land.
    always @(posedge clk) begin
        t_wheels exp_w;
        if (rst_n && wheels_valid && !wheels_stall) begin
            if (expected_wheels.size() == 0) begin
                $display("%0t: result with none expected: %h", $time, wheels);
                n_errors++;
            end else begin
                exp_w = expected_wheels.pop_front();
                n_checked++;
                if (exp_w.front_left_speed !== wheels.front_left_speed)
                    report_field("front_left_speed", exp_w.front_left_speed,
                                 wheels.front_left_speed);
                if (exp_w.front_right_speed !== wheels.front_right_speed)
                    report_field("front_right_speed", exp_w.front_right_speed,
                                 wheels.front_right_speed);
                if (exp_w.back_left_speed !== wheels.back_left_speed)
                    report_field("back_left_speed", exp_w.back_left_speed,
                                 wheels.back_left_speed);
                if (exp_w.back_right_speed !== wheels.back_right_speed)
                    report_field("back_right_speed", exp_w.back_right_speed,
                                 wheels.back_right_speed);
                if (exp_w.front_left_steer !== wheels.front_left_steer)
                    report_field("front_left_steer", exp_w.front_left_steer,
                                 wheels.front_left_steer);
                if (exp_w.front_right_steer !== wheels.front_right_steer)
                    report_field("front_right_steer", exp_w.front_right_steer,
                                 wheels.front_right_steer);
                if (exp_w.back_left_steer !== wheels.back_left_steer)
                    report_field("back_left_steer", exp_w.back_left_steer,
                                 wheels.back_left_steer);
                if (exp_w.back_right_steer !== wheels.back_right_steer)
                    report_field("back_right_steer", exp_w.back_right_steer,
                                 wheels.back_right_steer);
            end
        end
    end

    task automatic report_field(string name, logic [15:0] exp_v, logic [15:0] act_v);
        $display("%0t: %s expected %0d actual %0d", $time, name, exp_v, act_v);
        n_errors++;
    endtask

    function automatic t_cmd make_cmd(int x, int y, int r, int sc, bit fo, int hd,
                                      int a0, int a1, int a2, int a3);
        t_cmd c;
        c.x_command = x[15:0];
        c.y_command = y[15:0];
        c.rotation_command = r[15:0];
        c.speed_scale = sc[15:0];
        c.field_oriented = fo;
        c.robot_heading = hd[15:0];
        c.front_left_angle = a0[15:0];
        c.front_right_angle = a1[15:0];
        c.back_left_angle = a2[15:0];
        c.back_right_angle = a3[15:0];
        return c;
    endfunction

    function automatic int rand_q15();
        case ($urandom_range(9))
            0: return -32768;
            1: return 32767;
            2: return 0;
            3: return $urandom_range(64) - 32;
            default: return int'($urandom_range(65535)) - 32768;
        endcase
    endfunction

    function automatic t_cmd random_cmd();
        t_cmd         c;
        logic [159:0] raw;
        raw = {$urandom, $urandom, $urandom, $urandom, $urandom};
        c = raw[$bits(t_cmd)-1:0];
        c.x_command = 16'(rand_q15());
        c.y_command = 16'(rand_q15());
        c.rotation_command = 16'(rand_q15());
        case ($urandom_range(7))
            0: c.speed_scale = 16'h8000;
            1: c.speed_scale = 16'($urandom_range(65535, 32769));
            2: c.speed_scale = '0;
            default: c.speed_scale = 16'($urandom_range(32768));
        endcase
        // Now and then a fully stopped command, to exercise the hold path.
        if ($urandom_range(15) == 0) begin
            c.x_command = '0;
            c.y_command = '0;
            c.rotation_command = '0;
        end
        for (int k = 0; k < 4; k++) begin
            if ($urandom_range(15) != 0)
                c[16 * k +: 16] = 16'($urandom_range(46079));
        end
        return c;
    endfunction

    // ---------------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------------

    // Field extremes, stop command, scale saturation.
    task automatic test_directed();
        send_command(make_cmd(0, 0, 0, 32768, 0, 0, 0, 46079, 23040, 65535));
        send_command(make_cmd(0, 0, 0, 0, 1, 16384, 65535, 0, 46080, 9));
        send_command(make_cmd(32767, 0, 0, 32768, 0, 0, 0, 0, 0, 0));
        send_command(make_cmd(-32768, 0, 0, 32768, 0, 0, 0, 0, 0, 0));
        send_command(make_cmd(0, 32767, 0, 32768, 0, 0, 0, 0, 0, 0));
        send_command(make_cmd(0, -32768, 0, 32768, 0, 0, 0, 0, 0, 0));
        send_command(make_cmd(0, 0, 32767, 32768, 0, 0, 0, 0, 0, 0));
        send_command(make_cmd(0, 0, -32768, 32768, 0, 0, 0, 0, 0, 0));
        send_command(make_cmd(-32768, -32768, -32768, 65535, 0, 0, 0, 0, 0, 0));
        send_command(make_cmd(32767, 32767, 32767, 32769, 1, 65535, 0, 0, 0, 0));
        // Rotation equal to strafe and forward: the 1/sqrt2 scaling of rotation leaves every wheel vector nonzero.
        send_command(make_cmd(1, 1, 1, 32768, 0, 0, 0, 0, 0, 0));
        send_command(make_cmd(16384, -16384, 23170, 16384, 0, 0, 0, 0, 0, 0));
        send_command(make_cmd(16384, 8192, 0, 32768, 1, 32768, 0, 0, 0, 0));
        send_command(make_cmd(16384, 8192, 0, 32768, 1, 16384, 0, 0, 0, 0));
        send_command(make_cmd(16384, 8192, 0, 32768, 1, 49152, 0, 0, 0, 0));
        send_command(make_cmd(-1, 0, 0, 1, 1, 1, 0, 0, 0, 0));
        send_command(make_cmd(-300, 12000, -5000, 20000, 1, 43690, 0, 0, 0, 0));
        send_command(make_cmd(0, 0, 0, 65535, 0, 65535, 46079, 46079, 46079, 46079));
    endtask

    // Random commands; a middle stretch runs with no idling on either side.
    task automatic test_random();
        for (int i = 0; i < N_RANDOM; i++) begin
            if (i == N_RANDOM / 3) begin
                send_idle_pct = 0;
                recv_stall_pct = 0;
            end else if (i == N_RANDOM / 2) begin
                send_idle_pct = 21;
                recv_stall_pct = 21;
            end
            send_command(random_cmd());
        end
    endtask

    task automatic wait_drained();
        cmd_valid <= 1'b0;
        while (expected_wheels.size() != 0) @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
    endtask

    initial begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random();
        wait_drained();
        $display("Sent %0d commands (%0d stopped, %0d field oriented), checked %0d results.",
                 n_sent, n_zero_cmd, n_field, n_checked);
        if (n_errors == 0 && expected_wheels.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Timeout with %0d results outstanding", expected_wheels.size());
        $display("DONE: errors detected");
        $finish;
    end

endmodule
